### hdl/twt_pkg.sv
// package for the timer table core: codes, widths and the result type
// no dependencies
`timescale 1ns / 1ps
package twt_pkg;
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_UPDATE  = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_SOON  = 3'd4;

    localparam logic CFG_CHECK_INTERVAL = 1'b0;
    localparam logic CFG_TIME_ORIGIN    = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  owner;
        logic [15:0] id;
        logic        expired;
        logic        last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, reset scan
        logic prep;      // compute slot window
        logic scan;      // process entry at scan index
        logic commit;    // apply create or destroy
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic too_soon;
        logic hit;       // current entry is due to fire
    } stat_t;
endpackage

### hdl/timing_wheel_timer_table_core.sv
// timer table core: an item (create, destroy, update) is loaded, prepared, scanned over
// the table one entry per cycle unless stalled, then finished; a too-soon update skips the scan
// results leave through a one-deep output register; a fired item stalls the scan while it is busy
// reset: synchronous active low aresetn clears the table, config and control
// depends on twt_pkg, twt_ctrl, twt_datapath
`timescale 1ns / 1ps
module timing_wheel_timer_table_core #(
    parameter int TIMERS     = 32,
    parameter int SLOTS      = 64,
    parameter int SLOT_TICKS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // owner, timer_id, interval, call_count, now
    input  logic [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // status, fired_owner, fired_id, expired, zero pad
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    twt_pkg::cmd_t    cmd;
    twt_pkg::stat_t   stat;
    twt_pkg::result_t res, out_reg;
    logic emit_fire, emit_final, is_update, res_load, valid_reg, busy;

    assign busy = valid_reg && !m_tready;
    assign cfg_ready = 1'b1;

    twt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_op(s_tuser),
        .in_ready(s_tready), .out_busy(busy), .stat(stat), .cmd(cmd),
        .emit_fire(emit_fire), .emit_final(emit_final), .is_update(is_update)
    );

    twt_datapath #(.TIMERS(TIMERS), .SLOTS(SLOTS), .SLOT_TICKS(SLOT_TICKS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .is_update(is_update),
        .emit_fire(emit_fire), .emit_final(emit_final), .stat(stat),
        .in_op(s_tuser), .in_owner(s_tdata[7:0]), .in_id(s_tdata[23:8]),
        .in_interval(s_tdata[55:24]), .in_count(s_tdata[87:56]),
        .in_now(s_tdata[119:88]), .cfg_we(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .res(res), .res_load(res_load)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (res_load) valid_reg <= 1'b1;
        else if (m_tready) valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (res_load) out_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'd0, out_reg.expired, out_reg.id, out_reg.owner, out_reg.status};
endmodule

### hdl/twt_ctrl.sv
// controller state machine of the timer table core
// depends on twt_pkg
`timescale 1ns / 1ps
module twt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [1:0]      in_op,
    output logic            in_ready,
    input  logic            out_busy,
    input  twt_pkg::stat_t  stat,
    output twt_pkg::cmd_t   cmd,
    output logic            emit_fire,
    output logic            emit_final,
    output logic            is_update
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       upd_reg, upd_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign is_update = upd_reg;

    always_comb begin
        state_next = state_reg;
        upd_next   = upd_reg;
        cmd        = '0;
        emit_fire  = 1'b0;
        emit_final = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_op != twt_pkg::OP_IGNORED) begin
                    cmd.load   = 1'b1;
                    upd_next   = (in_op == twt_pkg::OP_UPDATE);
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                if (upd_reg && stat.too_soon) state_next = S_FIN;
                else state_next = S_SCAN;
            end
            S_SCAN: begin
                if (!(stat.hit && out_busy)) begin
                    cmd.scan  = 1'b1;
                    emit_fire = stat.hit;
                    if (stat.scan_done) state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!out_busy) begin
                    emit_final = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
        end
    end
endmodule

### hdl/twt_datapath.sv
// datapath of the timer table core: entry store, scan and slot arithmetic
// depends on twt_pkg
`timescale 1ns / 1ps
module twt_datapath #(
    parameter int TIMERS     = 32,
    parameter int SLOTS      = 64,
    parameter int SLOT_TICKS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  twt_pkg::cmd_t        cmd,
    input  logic                 is_update,
    input  logic                 emit_fire,
    input  logic                 emit_final,
    output twt_pkg::stat_t       stat,
    input  logic [1:0]           in_op,
    input  logic [7:0]           in_owner,
    input  logic [15:0]          in_id,
    input  logic [31:0]          in_interval,
    input  logic [31:0]          in_count,
    input  logic [31:0]          in_now,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    output twt_pkg::result_t     res,
    output logic                 res_load
);
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(TIMERS - 1);

    logic [TIMERS-1:0] valid_reg;
    logic [7:0]  own_mem  [TIMERS];
    logic [15:0] id_mem   [TIMERS];
    logic [31:0] ivl_mem  [TIMERS];
    logic [31:0] rem_mem  [TIMERS];
    logic [31:0] lf_mem   [TIMERS];
    logic [SW-1:0] slot_mem [TIMERS];

    logic [15:0] chk_reg;
    logic [31:0] origin_reg, lct_reg;
    logic [1:0]  op_reg;
    logic [7:0]  own_reg;
    logic [15:0] id_reg;
    logic [31:0] ivl_reg, cnt_reg, now_reg;
    logic [CW-1:0] idx_reg;
    logic        found_reg, free_ok_reg;
    logic [IW-1:0] found_idx_reg, free_idx_reg;
    logic [SW-1:0] start_reg, span_reg;
    logic [SW-1:0] slot_new_reg;
    logic        soon_reg;

    logic [IW-1:0] ix;
    assign ix = idx_reg[IW-1:0];

    function automatic logic [SW-1:0] slot_of(input logic [31:0] t, input logic [31:0] org);
        logic [31:0] rel;
        logic [31:0] q;
        begin
            rel = t - org;
            q = rel / SLOT_TICKS;
            slot_of = SW'(q % SLOTS);
        end
    endfunction

    function automatic logic [31:0] in_now_diff(input logic [31:0] a, input logic [31:0] b);
        in_now_diff = a - b;
    endfunction

    // slot offset from window start, modulo slots
    logic [SW:0] off_raw;
    logic [SW-1:0] off;
    always_comb begin
        off_raw = {1'b0, slot_mem[ix]} + (SW+1)'(SLOTS) - {1'b0, start_reg};
        off = (off_raw >= (SW+1)'(SLOTS)) ? SW'(off_raw - (SW+1)'(SLOTS)) : off_raw[SW-1:0];
    end

    // slot window width, modulo slots
    logic [SW-1:0] lct_slot, now_slot;
    logic [SW:0] span_raw;
    logic [SW-1:0] span_mod;
    assign lct_slot = slot_of(lct_reg, origin_reg);
    assign now_slot = slot_of(now_reg, origin_reg);
    always_comb begin
        span_raw = {1'b0, now_slot} + (SW+1)'(SLOTS) - {1'b0, lct_slot};
        span_mod = (span_raw >= (SW+1)'(SLOTS)) ? SW'(span_raw - (SW+1)'(SLOTS))
                                                 : span_raw[SW-1:0];
    end

    logic due, hit, expd;
    logic [31:0] rem_dec;
    assign due  = (in_now_diff(now_reg, lf_mem[ix]) >= ivl_mem[ix]);
    assign hit  = is_update && valid_reg[ix] && (off <= span_reg) && due;
    assign rem_dec = rem_mem[ix] - 32'd1;
    assign expd = (rem_mem[ix] == 32'd1);

    logic [31:0] ivl_eff;
    assign ivl_eff = (in_interval == 32'd0) ? 32'd1 : in_interval;

    assign stat.scan_done = (idx_reg == LAST_IDX);
    assign stat.too_soon  = ((now_reg - lct_reg) < {16'd0, chk_reg});
    assign stat.hit       = hit;

    // slot of the next due time for a firing entry, written to the slot store on a hit
    logic [SW-1:0] fire_slot;
    assign fire_slot = slot_of(now_reg + ivl_mem[ix], origin_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            chk_reg    <= 16'd16;
            origin_reg <= '0;
            lct_reg    <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == twt_pkg::CFG_CHECK_INTERVAL) chk_reg <= cfg_data[15:0];
                else begin
                    origin_reg <= cfg_data;
                    lct_reg    <= cfg_data;
                end
            end
            if (cmd.prep && is_update && !stat.too_soon) lct_reg <= now_reg;
            if (cmd.scan && hit && expd) valid_reg[ix] <= 1'b0;
            if (cmd.commit && !is_update) begin
                if (op_reg == twt_pkg::OP_CREATE && !found_reg && free_ok_reg)
                    valid_reg[free_idx_reg] <= 1'b1;
                if (op_reg == twt_pkg::OP_DESTROY && found_reg)
                    valid_reg[found_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            own_reg <= in_owner;
            id_reg  <= in_id;
            ivl_reg <= ivl_eff;
            cnt_reg <= in_count;
            now_reg <= in_now;
            idx_reg <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg  <= '0;
        end
        if (cmd.prep) begin
            start_reg <= lct_slot;
            span_reg  <= span_mod;
            slot_new_reg <= slot_of(lct_reg + ivl_reg, origin_reg);
            soon_reg  <= stat.too_soon;
        end
        if (cmd.scan) begin
            if (!stat.scan_done) idx_reg <= idx_reg + CW'(1);
            if (!is_update) begin
                if (valid_reg[ix]) begin
                    if (!found_reg && own_mem[ix] == own_reg && id_mem[ix] == id_reg) begin
                        found_reg <= 1'b1;
                        found_idx_reg <= ix;
                    end
                end else if (!free_ok_reg) begin
                    free_ok_reg <= 1'b1;
                    free_idx_reg <= ix;
                end
            end else if (hit) begin
                lf_mem[ix] <= now_reg;
                if (rem_mem[ix] != 32'd0) rem_mem[ix] <= rem_dec;
                if (!expd) slot_mem[ix] <= fire_slot;
            end
        end
        if (cmd.commit && !is_update && op_reg == twt_pkg::OP_CREATE
            && !found_reg && free_ok_reg) begin
            own_mem[free_idx_reg]  <= own_reg;
            id_mem[free_idx_reg]   <= id_reg;
            ivl_mem[free_idx_reg]  <= ivl_reg;
            rem_mem[free_idx_reg]  <= cnt_reg;
            lf_mem[free_idx_reg]   <= lct_reg;
            slot_mem[free_idx_reg] <= slot_new_reg;
        end
    end

    always_comb begin
        res = '0;
        res_load = emit_fire | emit_final;
        if (emit_fire) begin
            res.kind    = twt_pkg::KIND_FIRED;
            res.owner   = own_mem[ix];
            res.id      = id_mem[ix];
            res.expired = expd;
        end else if (is_update) begin
            res.kind   = twt_pkg::KIND_DONE;
            res.status = soon_reg ? twt_pkg::ST_TOO_SOON : twt_pkg::ST_OK;
            res.last   = 1'b1;
        end else begin
            res.kind  = twt_pkg::KIND_STATUS;
            res.owner = own_reg;
            res.id    = id_reg;
            res.last  = 1'b1;
            if (op_reg == twt_pkg::OP_CREATE) begin
                if (found_reg) res.status = twt_pkg::ST_EXISTS;
                else if (!free_ok_reg) res.status = twt_pkg::ST_FULL;
            end else if (!found_reg) res.status = twt_pkg::ST_NOT_FOUND;
        end
    end
endmodule
